@@ rtl/twm_pkg.sv @@
// Package for the text width measurement block: item and result types,
// character classes, status and register codes. No dependencies.
package twm_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
	localparam int MAX_STRING  = 4096;
	localparam int INDEX_W     = $clog2(MAX_STRING);
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	localparam int SUM_W   = 24;
	localparam int LEFT_W  = 14;
	localparam int LIMIT_W = 12;
	localparam int FITL_W  = 23;
	localparam int BRK_W   = 12;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CHAR = 1'b1;

	localparam logic REG_SPACE_WIDTH = 1'b0;
	localparam logic REG_TRACKING    = 1'b1;

	typedef enum logic [2:0] {
		CC_NUL,
		CC_SPACE,
		CC_TILDE,
		CC_BAR,
		CC_LT,
		CC_GT,
		CC_GLYPH
	} char_class_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_EXCEED = 2'd1,
		ST_BREAK  = 2'd2,
		ST_END    = 2'd3
	} status_t;

	typedef struct packed {
		logic                op;
		char_class_t         cls;
		logic [7:0]          char_code;
		logic [7:0]          glyph_width;
		logic                start_req;
		logic                last;
		logic                fit_mode;
		logic                tags_enabled;
		logic [LIMIT_W-1:0]  char_limit;
		logic [FITL_W-1:0]   fit_limit;
	} item_t;

	typedef struct packed {
		logic valid;
		logic idx;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

@@ rtl/twm_front.sv @@
// Front part: accepts stream items, classifies the character byte and
// pushes the decoded item into the queue. Depends on twm_pkg.
module twm_front import twm_pkg::*; (
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	// char_code, glyph_width, start_req, fit_mode, tags_enabled, char_limit, fit_limit
	input  logic [55:0] s_axis_tdata,
	input  logic        q_ready,
	output logic        q_push,
	output item_t       q_item
);

	char_class_t cls;

	always_comb begin
		case (s_axis_tdata[7:0])
			CH_NUL:   cls = CC_NUL;
			CH_SPACE: cls = CC_SPACE;
			CH_TILDE: cls = CC_TILDE;
			CH_BAR:   cls = CC_BAR;
			CH_LT:    cls = CC_LT;
			CH_GT:    cls = CC_GT;
			default:  cls = CC_GLYPH;
		endcase
	end

	always_comb begin
		q_item.op           = s_axis_tuser;
		q_item.cls          = cls;
		q_item.char_code    = s_axis_tdata[7:0];
		q_item.glyph_width  = s_axis_tdata[15:8];
		q_item.start_req    = s_axis_tdata[16];
		q_item.last         = s_axis_tlast;
		q_item.fit_mode     = s_axis_tdata[17];
		q_item.tags_enabled = s_axis_tdata[18];
		q_item.char_limit   = s_axis_tdata[30:19];
		q_item.fit_limit    = s_axis_tdata[53:31];
	end

	assign s_axis_tready = q_ready;
	assign q_push        = s_axis_tvalid & q_ready;

endmodule

@@ rtl/twm_fifo.sv @@
// Short queue of decoded items between the front and back parts.
// Depends on twm_pkg.
module twm_fifo import twm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  push_ready,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	item_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue count beyond depth");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - (FIFO_AW+1)'(1))
		else $error("queue count not decremented on pop");
`endif

endmodule

@@ rtl/twm_back.sv @@
// Back part: glyph width memory, per-string measuring state and the
// result register. Depends on twm_pkg; fed from twm_fifo.
module twm_back import twm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, text_width, break_index
	output logic [39:0] m_axis_tdata
);

	logic [7:0]              glyph_mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0]  gvalid_q;
	logic [7:0]              space_width_q;
	logic signed [7:0]       tracking_q;

	logic                    valid_s1;
	item_t                   item_s1;
	logic [7:0]              rd_s1;
	logic                    gv_s1;

	logic signed [SUM_W-1:0]  ws_q;
	logic signed [LEFT_W-1:0] left_q;
	logic [INDEX_W-1:0]       idx_q;
	logic                     tag_q;
	logic                     done_q;
	logic                     fit_q;
	logic                     tags_q;
	logic                     limited_q;
	logic [FITL_W-1:0]        fitl_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [SUM_W-1:0]  out_width_q;
	logic [BRK_W-1:0]         out_brk_q;

	logic                     advance;
	logic                     step;

	logic signed [SUM_W-1:0]  n_ws;
	logic signed [LEFT_W-1:0] n_left;
	logic [INDEX_W-1:0]       n_idx;
	logic                     n_tag;
	logic                     n_done;
	logic                     n_fit;
	logic                     n_tags;
	logic                     n_limited;
	logic [FITL_W-1:0]        n_fitl;
	logic                     emit;
	status_t                  e_status;
	logic [BRK_W-1:0]         e_brk;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [9:0]       b
	);
		logic signed [SUM_W:0] s;
		begin
			s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
			if (s[SUM_W] != s[SUM_W-1]) begin
				sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sat_add = s[SUM_W-1:0];
			end
		end
	endfunction

	assign advance = !out_valid_q || m_axis_tready;
	assign q_pop   = q_valid & advance;
	assign step    = valid_s1 & advance;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_item.op == OP_LOAD) begin
				glyph_mem[q_item.char_code[GLYPH_AW-1:0]] <= q_item.glyph_width;
			end
			rd_s1   <= glyph_mem[q_item.char_code[GLYPH_AW-1:0]];
			item_s1 <= q_item;
		end
	end

	always_comb begin
		logic signed [9:0]       glyph_add;
		logic [7:0]              gw;
		logic [INDEX_W-1:0]      idx_inc;
		gw        = gv_s1 ? rd_s1 : 8'd0;
		glyph_add = $signed({2'b00, gw}) + {{2{tracking_q[7]}}, tracking_q};
		idx_inc   = (idx_q == {INDEX_W{1'b1}}) ? idx_q : idx_q + INDEX_W'(1);
		n_ws      = ws_q;
		n_left    = left_q;
		n_idx     = idx_q;
		n_tag     = tag_q;
		n_done    = done_q;
		n_fit     = fit_q;
		n_tags    = tags_q;
		n_limited = limited_q;
		n_fitl    = fitl_q;
		emit      = 1'b0;
		e_status  = ST_DONE;
		e_brk     = '0;
		if (item_s1.op == OP_CHAR) begin
			if (item_s1.start_req) begin
				n_fit     = item_s1.fit_mode;
				n_tags    = item_s1.tags_enabled;
				n_limited = item_s1.char_limit != '0;
				n_left    = $signed(LEFT_W'(item_s1.char_limit));
				n_fitl    = item_s1.fit_limit;
				n_ws      = '0;
				n_idx     = '0;
				n_tag     = 1'b0;
				n_done    = 1'b0;
				idx_inc   = INDEX_W'(1);
			end
			if (!n_done) begin
				if (n_fit) begin
					case (item_s1.cls)
						CC_NUL: begin
							emit     = 1'b1;
							e_status = ST_END;
						end
						CC_BAR: begin
							emit     = 1'b1;
							e_status = ST_BREAK;
							e_brk    = BRK_W'(idx_inc);
						end
						CC_SPACE: n_ws = sat_add(n_ws, $signed({2'b00, space_width_q}));
						CC_TILDE: n_ws = n_ws;
						default:  n_ws = sat_add(n_ws, glyph_add);
					endcase
					if (!emit) begin
						if (n_ws > $signed({1'b0, n_fitl})) begin
							emit     = 1'b1;
							e_status = ST_EXCEED;
							e_brk    = BRK_W'(n_idx);
						end else begin
							n_idx = idx_inc;
							if (item_s1.last) begin
								emit     = 1'b1;
								e_status = ST_END;
							end
						end
					end
				end else begin
					if (item_s1.cls == CC_NUL) begin
						emit = 1'b1;
					end else if (n_tag) begin
						if (item_s1.cls == CC_GT) begin
							n_tag = 1'b0;
						end else if (n_left != {1'b1, {(LEFT_W-1){1'b0}}}) begin
							n_left = n_left - LEFT_W'(1);
						end
					end else if (item_s1.cls == CC_BAR) begin
						emit = 1'b1;
					end else begin
						case (item_s1.cls)
							CC_SPACE: n_ws = sat_add(n_ws, $signed({2'b00, space_width_q}));
							CC_TILDE: n_ws = n_ws;
							CC_LT: begin
								if (n_tags) begin
									n_tag = 1'b1;
								end else begin
									n_ws = sat_add(n_ws, glyph_add);
								end
							end
							default:  n_ws = sat_add(n_ws, glyph_add);
						endcase
						if (n_left != {1'b1, {(LEFT_W-1){1'b0}}}) begin
							n_left = n_left - LEFT_W'(1);
						end
					end
					if (!emit) begin
						if (!n_tag && n_limited && (n_left[LEFT_W-1] || n_left == '0)) begin
							emit = 1'b1;
						end else if (item_s1.last) begin
							emit = 1'b1;
						end
					end
				end
				if (emit) begin
					n_done = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvalid_q      <= '0;
			gv_s1         <= 1'b0;
			valid_s1      <= 1'b0;
			space_width_q <= '0;
			tracking_q    <= '0;
			ws_q          <= '0;
			left_q        <= '0;
			idx_q         <= '0;
			tag_q         <= 1'b0;
			done_q        <= 1'b1;
			fit_q         <= 1'b0;
			tags_q        <= 1'b0;
			limited_q     <= 1'b0;
			fitl_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.idx)
					REG_SPACE_WIDTH: space_width_q <= cfg.data;
					REG_TRACKING:    tracking_q    <= $signed(cfg.data);
					default:         space_width_q <= space_width_q;
				endcase
			end
			if (q_pop) begin
				gv_s1 <= gvalid_q[q_item.char_code[GLYPH_AW-1:0]];
				if (q_item.op == OP_LOAD) begin
					gvalid_q[q_item.char_code[GLYPH_AW-1:0]] <= 1'b1;
				end
			end
			if (advance) begin
				valid_s1 <= q_valid;
			end
			if (step) begin
				ws_q      <= n_ws;
				left_q    <= n_left;
				idx_q     <= n_idx;
				tag_q     <= n_tag;
				done_q    <= n_done;
				fit_q     <= n_fit;
				tags_q    <= n_tags;
				limited_q <= n_limited;
				fitl_q    <= n_fitl;
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_status_q <= e_status;
			out_width_q  <= n_ws;
			out_brk_q    <= e_brk;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_brk_q, out_width_q, out_status_q};

`ifndef NO_ASSERTIONS
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> done_q && out_valid_q)
		else $error("result given without closing the string");
	a_fit_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		fit_q |-> !tag_q)
		else $error("tag state set in fit mode");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(ws_q))
		else $error("stage lost its item under stall");
`endif

endmodule

@@ rtl/text_width_measure.sv @@
// Text width measurement block, top level.
// Instantiates twm_front, twm_fifo and twm_back; uses twm_pkg.
//
// Items arrive on the s_axis stream: tuser carries op (0 loads a glyph
// width into the 256-entry table, 1 is a string character) and tlast
// marks the final character of a string. Each finished string yields one
// transfer on m_axis with status, text width and break index.
// Registers space_width (index 0) and tracking (index 1) are written on the
// cfg channel, which is always ready; write them only while the block is idle.
// One item is taken per cycle while s_axis_tready is high. A result passes
// through the queue, the registered read of the glyph width memory and the
// output register after the transfer of the character that ends the string.
// When the receiver stalls, the result stays in the output register and
// the back part holds; the four-entry queue then fills and s_axis_tready
// falls. Reset clears the glyph table to zero widths, both registers and
// all string state; no item is lost or repeated across stalls.
module text_width_measure import twm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	// char_code, glyph_width, start_req, fit_mode, tags_enabled, char_limit, fit_limit
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, text_width, break_index
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	item_t   push_item;
	item_t   pop_item;
	logic    push;
	logic    push_ready;
	logic    pop;
	logic    pop_valid;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.idx   = cfg_index;
	assign cfg.data  = cfg_data;

	twm_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tdata  (s_axis_tdata),
		.q_ready       (push_ready),
		.q_push        (push),
		.q_item        (push_item)
	);

	twm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	twm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (pop_valid),
		.q_item        (pop_item),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ tb/sv/text_width_measure_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_width_measure: a directed table followed by random strings,
// each result checked against a predictor of the width logic, or a fixed value for typed table rows.
// Depends on twm_pkg and the text_width_measure RTL.
module text_width_measure_tb import twm_pkg::*; ();

	localparam int SUM_MAX    = 8388607;
	localparam int SUM_MIN    = -8388608;
	localparam int LEFT_FLOOR = -8192;
	localparam int SETTLE     = 8;
	localparam int CYCLE_CAP  = 20000;
	localparam int PHASE_ITEMS = 155;

	typedef struct packed {
		logic               op;
		logic [7:0]         code;
		logic [7:0]         gw;
		logic               start;
		logic               last;
		logic               fit;
		logic               tags;
		logic [LIMIT_W-1:0] lim;
		logic [FITL_W-1:0]  flim;
	} char_item_t;

	typedef struct packed {
		status_t            status;
		logic [SUM_W-1:0]   width;
		logic [BRK_W-1:0]   brk;
	} text_result_t;

	typedef struct packed {
		char_item_t   it;
		logic         typed;
		text_result_t want;
	} plan_row_t;

	localparam text_result_t NONE_TYPED = '0;
	localparam text_result_t DONE_ZERO  = '{ST_DONE, 24'd0, 12'd0};
	localparam text_result_t END_ZERO   = '{ST_END, 24'd0, 12'd0};
	localparam text_result_t BREAK_ONE  = '{ST_BREAK, 24'd0, 12'd1};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	text_width_measure DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state.
	logic [7:0]        glyph_tab [0:GLYPH_COUNT-1];
	logic [7:0]        space_reg = '0;
	logic signed [7:0] tracking_reg = '0;
	int                width_acc = 0;
	int                left = 0;
	int unsigned       char_idx = 0;
	bit                in_tag = 1'b0;
	bit                str_open = 1'b0;
	bit                fit_lat = 1'b0;
	bit                tags_lat = 1'b0;
	bit                limited = 1'b0;
	int                fit_limit_lat = 0;

	text_result_t pending_results [$];
	int           mismatches = 0;
	int           cycles = 0;
	int           sent = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	function automatic char_item_t ch(input logic [7:0] code, input logic start, input logic last,
			input logic fit, input logic tags, input logic [LIMIT_W-1:0] lim,
			input logic [FITL_W-1:0] flim);
		return '{OP_CHAR, code, 8'd0, start, last, fit, tags, lim, flim};
	endfunction

	function automatic char_item_t ld(input logic [7:0] code, input logic [7:0] w);
		return '{OP_LOAD, code, w, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 23'd0};
	endfunction

	function automatic void add_to_sum(input int v);
		int s;
		s = width_acc + v;
		if (s > SUM_MAX) s = SUM_MAX;
		else if (s < SUM_MIN) s = SUM_MIN;
		width_acc = s;
	endfunction

	function automatic bit end_string(input status_t st, input int unsigned idx,
			output text_result_t r);
		r.status = st;
		r.width = width_acc[SUM_W-1:0];
		r.brk = (idx > 4095) ? 12'hFFF : idx[BRK_W-1:0];
		str_open = 1'b0;
		return 1'b1;
	endfunction

	function automatic bit measure_char(input char_item_t it, output text_result_t r);
		int unsigned i;
		int glyph;
		r = '0;
		if (it.op == OP_LOAD) begin
			glyph_tab[it.code] = it.gw;
			return 1'b0;
		end
		if (it.start) begin
			fit_lat = it.fit;
			tags_lat = it.tags;
			limited = (it.lim != 0);
			left = int'(it.lim);
			fit_limit_lat = int'(it.flim);
			width_acc = 0;
			char_idx = 0;
			in_tag = 1'b0;
			str_open = 1'b1;
		end
		if (!str_open)
			return 1'b0;
		glyph = int'(glyph_tab[it.code]) + int'(tracking_reg);
		if (fit_lat) begin
			i = char_idx;
			if (it.code == CH_NUL)
				return end_string(ST_END, 0, r);
			if (it.code == CH_BAR)
				return end_string(ST_BREAK, i + 1, r);
			if (it.code == CH_SPACE)
				add_to_sum(int'(space_reg));
			else if (it.code != CH_TILDE)
				add_to_sum(glyph);
			if (width_acc > fit_limit_lat)
				return end_string(ST_EXCEED, i, r);
			if (char_idx < MAX_STRING - 1)
				char_idx++;
			if (it.last)
				return end_string(ST_END, 0, r);
			return 1'b0;
		end
		if (it.code == CH_NUL)
			return end_string(ST_DONE, 0, r);
		if (in_tag) begin
			if (it.code == CH_GT)
				in_tag = 1'b0;
			else if (left > LEFT_FLOOR)
				left--;
		end else begin
			if (it.code == CH_BAR)
				return end_string(ST_DONE, 0, r);
			if (it.code == CH_SPACE)
				add_to_sum(int'(space_reg));
			else if (it.code == CH_LT && tags_lat)
				in_tag = 1'b1;
			else if (it.code != CH_TILDE)
				add_to_sum(glyph);
			if (left > LEFT_FLOOR)
				left--;
		end
		if (!in_tag && limited && left <= 0)
			return end_string(ST_DONE, 0, r);
		if (it.last)
			return end_string(ST_DONE, 0, r);
		return 1'b0;
	endfunction

	task automatic send_item(input char_item_t it, input logic typed = 1'b0,
			input text_result_t want = '0);
		text_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tlast <= it.last;
		s_axis_tdata <= {2'b00, it.flim, it.lim, it.tags, it.fit, it.start, it.gw, it.code};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
		if (measure_char(it, r))
			pending_results.push_back(typed ? want : r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] sw, input logic [7:0] tr);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SPACE_WIDTH;
		cfg_data <= sw;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		space_reg = sw;
		cfg_index <= REG_TRACKING;
		cfg_data <= tr;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracking_reg = tr;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_string();
		int n;
		int p;
		logic fit;
		logic tags;
		logic [LIMIT_W-1:0] lim;
		logic [FITL_W-1:0] flim;
		char_item_t it;
		n = $urandom_range(1, 8);
		fit = $urandom_range(0, 1);
		tags = ($urandom_range(0, 2) != 0);
		case ($urandom_range(0, 3))
			0, 1: lim = '0;
			2: lim = $urandom_range(1, 8);
			default: lim = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: flim = $urandom_range(0, 600);
			1: flim = $urandom_range(0, 3000);
			2: flim = $urandom;
			default: flim = '1;
		endcase
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ld($urandom_range(8'h41, 8'h5A), $urandom));
			p = $urandom_range(0, 99);
			if (p < 12) it.code = CH_SPACE;
			else if (p < 20) it.code = CH_TILDE;
			else if (p < 25) it.code = CH_BAR;
			else if (p < 33) it.code = CH_LT;
			else if (p < 41) it.code = CH_GT;
			else if (p < 44) it.code = CH_NUL;
			else if (p < 75) it.code = $urandom_range(8'h41, 8'h5A);
			else it.code = $urandom;
			it.op = OP_CHAR;
			it.gw = $urandom;
			it.start = (k == 0);
			it.last = (k == n - 1) && ($urandom_range(0, 7) != 0);
			it.fit = (k == 0) ? fit : $urandom_range(0, 1);
			it.tags = (k == 0) ? tags : $urandom_range(0, 1);
			it.lim = (k == 0) ? lim : $urandom;
			it.flim = (k == 0) ? flim : $urandom;
			send_item(it);
		end
	endtask

	task automatic run_phase(input int snd_pct, input int rcv_pct, input logic [7:0] sw,
			input logic [7:0] tr);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		set_regs(sw, tr);
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			case ($urandom_range(0, 11))
				0, 1: send_item(ld(($urandom_range(0, 2) != 0) ? $urandom_range(8'h41, 8'h5A)
						: $urandom_range(0, 255), ($urandom_range(0, 7) == 0) ? 8'd0 : $urandom));
				2: send_item(ch($urandom, 1'b0, $urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom, $urandom));
				default: random_string();
			endcase
		end
		send_item(ch("A", 1'b1, 1'b1, 1'b0, 1'b0, 12'd0, 23'd0));
		drain();
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		text_result_t got;
		text_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tdata[1:0]);
				got.width = m_axis_tdata[25:2];
				got.brk = m_axis_tdata[37:26];
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("Unexpected result: status %0d width %0d index %0d",
							got.status, $signed(got.width), got.brk);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.width !== want.width
							|| got.brk !== want.brk) begin
						if (mismatches < 10)
							$display({"Result mismatch: status %0d/%0d width %0d/%0d",
								" index %0d/%0d (expected/actual)"},
								want.status, got.status, $signed(want.width),
								$signed(got.width), want.brk, got.brk);
						mismatches++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		plan_row_t plan [$];
		for (int k = 0; k < GLYPH_COUNT; k++)
			glyph_tab[k] = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SPACE_WIDTH;
		cfg_data = '0;
		plan = '{
			'{ch("A", 1, 1, 0, 0, 0, 0), 1'b1, DONE_ZERO},
			'{ch(CH_NUL, 1, 0, 1, 0, 0, 0), 1'b1, END_ZERO},
			'{ch(CH_BAR, 1, 1, 1, 0, 0, 0), 1'b1, BREAK_ONE},
			'{ld("A", 8'd255), 1'b0, NONE_TYPED},
			'{ld(8'hFF, 8'd1), 1'b0, NONE_TYPED},
			'{ld(8'h80, 8'd128), 1'b0, NONE_TYPED},
			'{ch("A", 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch("A", 1, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_SPACE, 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_TILDE, 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(8'hFF, 0, 1, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_LT, 1, 0, 0, 1, 3, 0), 1'b0, NONE_TYPED},
			'{ch(CH_BAR, 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_GT, 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch("A", 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch("A", 1, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch("A", 1, 0, 1, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch("A", 1, 0, 1, 0, 0, 23'h7FFFFF), 1'b0, NONE_TYPED},
			'{ch(CH_BAR, 0, 0, 0, 0, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_NUL, 1, 0, 0, 0, 0, 0), 1'b1, DONE_ZERO},
			'{ch(CH_BAR, 1, 0, 0, 0, 0, 0), 1'b1, DONE_ZERO},
			'{ch(CH_LT, 1, 1, 0, 1, 12'hFFF, 23'h7FFFFF), 1'b1, DONE_ZERO},
			'{ch(CH_TILDE, 1, 1, 1, 0, 0, 0), 1'b1, END_ZERO},
			'{ch(CH_LT, 1, 0, 0, 1, 0, 0), 1'b0, NONE_TYPED},
			'{ch(CH_NUL, 0, 0, 0, 0, 0, 0), 1'b1, DONE_ZERO}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 68;
		foreach (plan[k])
			send_item(plan[k].it, plan[k].typed, plan[k].want);
		drain();

		run_phase(31, 68, 8'd255, 8'h7F);
		run_phase(68, 31, 8'd0, 8'h80);
		run_phase(0, 0, $urandom, $urandom);

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ text_width_measure.f @@
rtl/twm_pkg.sv
rtl/twm_front.sv
rtl/twm_fifo.sv
rtl/twm_back.sv
rtl/text_width_measure.sv
tb/sv/text_width_measure_tb.sv
